// File: hw/rtl/csad_pkg.sv
// Shared constants, types and register codes for the class score argmax debouncer.
// No dependencies; imported by every module of the block.
package csad_pkg;

  localparam int NUM_LABELS = 8;
  localparam int SCORE_BITS = 16;
  localparam int LABEL_BITS = $clog2(NUM_LABELS);
  localparam int COUNT_BITS = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 4'd15;
  localparam logic [LABEL_BITS-1:0] LAST_INDEX = LABEL_BITS'(NUM_LABELS - 1);
  localparam logic signed [SCORE_BITS-1:0] SCORE_MIN =
    {1'b1, {(SCORE_BITS-1){1'b0}}};

  localparam logic signed [SCORE_BITS-1:0] THRESHOLD_RESET = 16'sd29491;
  localparam logic [COUNT_BITS-1:0] CONFIRM_RESET = 4'd3;
  localparam logic [2:0] IGNORE_A_RESET = 3'd0;
  localparam logic [2:0] IGNORE_B_RESET = 3'd6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_CONFIRM   = 2'd1,
    REG_IGNORE_A  = 2'd2,
    REG_IGNORE_B  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] threshold;
    logic [COUNT_BITS-1:0]        confirm;
    logic [2:0]                   ignore_a;
    logic [2:0]                   ignore_b;
  } cfg_t;

  typedef struct packed {
    logic                         done;
    logic [LABEL_BITS-1:0]        label;
    logic signed [SCORE_BITS-1:0] best;
  } frame_res_t;

endpackage

// File: hw/rtl/csad_cfg.sv
// Configuration register file: threshold, confirm count and ignored labels.
// Depends on csad_pkg.
module csad_cfg
  import csad_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RESET;
      cfg_r.confirm   <= CONFIRM_RESET;
      cfg_r.ignore_a  <= IGNORE_A_RESET;
      cfg_r.ignore_b  <= IGNORE_B_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD: cfg_r.threshold <= cfg_data[SCORE_BITS-1:0];
        REG_CONFIRM:   cfg_r.confirm   <= cfg_data[COUNT_BITS-1:0];
        REG_IGNORE_A:  cfg_r.ignore_a  <= cfg_data[2:0];
        REG_IGNORE_B:  cfg_r.ignore_b  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/csad_scan.sv
// Frame scanner: running maximum and its index over the scores of one frame.
// Depends on csad_pkg.
module csad_scan
  import csad_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic signed [SCORE_BITS-1:0] score,
  input  logic                         frame_end,
  output frame_res_t                   res
);

  logic [LABEL_BITS-1:0]        idx_r, idx_nxt;
  logic                         full_r, full_nxt;
  logic signed [SCORE_BITS-1:0] max_r, max_nxt;
  logic [LABEL_BITS-1:0]        best_r, best_nxt;

  logic signed [SCORE_BITS-1:0] max_upd;
  logic [LABEL_BITS-1:0]        best_upd;

  always_comb begin
    max_upd  = max_r;
    best_upd = best_r;
    idx_nxt  = idx_r;
    full_nxt = full_r;
    // strict compare: first index wins a tie
    if (!full_r) begin
      if (score > max_r) begin
        max_upd  = score;
        best_upd = idx_r;
      end
      if (idx_r == LAST_INDEX) full_nxt = 1'b1;
      else                     idx_nxt  = idx_r + 1'b1;
    end
    max_nxt  = max_upd;
    best_nxt = best_upd;
    if (frame_end) begin
      idx_nxt  = '0;
      full_nxt = 1'b0;
      max_nxt  = SCORE_MIN;
      best_nxt = '0;
    end
    res.done  = take && frame_end;
    res.label = best_upd;
    res.best  = max_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      full_r <= 1'b0;
      max_r  <= SCORE_MIN;
      best_r <= '0;
    end else if (take) begin
      idx_r  <= idx_nxt;
      full_r <= full_nxt;
      max_r  <= max_nxt;
      best_r <= best_nxt;
    end
  end

endmodule

// File: hw/rtl/csad_debounce.sv
// Label debouncer with the result register that drives the output channel.
// Depends on csad_pkg.
module csad_debounce
  import csad_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  frame_res_t                   res,
  input  cfg_t                         cfg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LABEL_BITS-1:0]        out_label,
  output logic                         out_publish,
  output logic signed [SCORE_BITS-1:0] out_best_score
);

  logic [LABEL_BITS-1:0] prev_r, prev_nxt;
  logic                  prev_vld_r, prev_vld_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [LABEL_BITS-1:0] acc_r, acc_nxt;
  logic                  acc_vld_r, acc_vld_nxt;
  logic                  emit;

  logic                         out_valid_r;
  logic [LABEL_BITS-1:0]        label_r;
  logic                         publish_r;
  logic signed [SCORE_BITS-1:0] best_r;

  always_comb begin
    prev_nxt     = prev_r;
    prev_vld_nxt = prev_vld_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    acc_vld_nxt  = acc_vld_r;
    emit         = 1'b0;
    if (res.done && !(res.best < cfg.threshold)) begin
      if (prev_vld_r && prev_r == res.label) begin
        if (cnt_r < COUNT_MAX) cnt_nxt = cnt_r + 1'b1;
      end else begin
        cnt_nxt      = COUNT_BITS'(1);
        prev_nxt     = res.label;
        prev_vld_nxt = 1'b1;
      end
      if (cnt_nxt >= cfg.confirm && !(acc_vld_r && acc_r == res.label)) begin
        emit        = 1'b1;
        acc_nxt     = res.label;
        acc_vld_nxt = 1'b1;
        cnt_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      prev_vld_r  <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
      acc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      prev_vld_r <= prev_vld_nxt;
      cnt_r      <= cnt_nxt;
      acc_r      <= acc_nxt;
      acc_vld_r  <= acc_vld_nxt;
      if (emit)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload: load on a new result only
  always_ff @(posedge clk) begin
    if (emit) begin
      label_r   <= res.label;
      publish_r <= (res.label != cfg.ignore_a) && (res.label != cfg.ignore_b);
      best_r    <= res.best;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_label      = label_r;
  assign out_publish    = publish_r;
  assign out_best_score = best_r;

endmodule

// File: hw/rtl/class_score_argmax_debouncer_core.sv
// Class score argmax debouncer, top level.
// A confirmed label is registered and appears on the output in the cycle after the frame_end word is taken.
// Throughput: one score word per cycle while in_ready is high, set by the single compare-and-count pass.
// The output register holds one result; a new word is taken while it is free or drained.
// Reset (rst_n low, synchronous): configuration registers to defaults, frame scan and debouncer cleared.
// Depends on csad_pkg, csad_cfg, csad_scan and csad_debounce.
module class_score_argmax_debouncer_core
  import csad_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // score stream
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SCORE_BITS-1:0] in_score,
  input  logic                         in_frame_end,
  // confirmed labels
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LABEL_BITS-1:0]        out_label,
  output logic                         out_publish,
  output logic signed [SCORE_BITS-1:0] out_best_score,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  cfg_t       cfg;
  frame_res_t res;
  logic       take;

  // Accept a word whenever the result register is empty or being drained this
  // cycle, so a frame end can always land its result without overwriting one.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Hold the threshold, confirm count and the two ignored labels.
  csad_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Track the best score of the running frame; report it on the frame end word.
  csad_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .score     (in_score),
    .frame_end (in_frame_end),
    .res       (res)
  );

  // Qualify against the threshold, count repeats and register a confirmed label.
  csad_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_label      (out_label),
    .out_publish    (out_publish),
    .out_best_score (out_best_score)
  );

endmodule
